// ----- hw/rtl/btl_pkg.sv -----
// Shared types, character codes, token kinds and keyword table for the BASIC token lexer.
package btl_pkg;

    typedef enum logic [5:0] {
        MODE_IDLE = 6'b000001,
        MODE_OP   = 6'b000010,
        MODE_STR  = 6'b000100,
        MODE_NUM  = 6'b001000,
        MODE_WORD = 6'b010000,
        MODE_ERR  = 6'b100000
    } t_mode;

    localparam logic [4:0] KIND_NEWLINE = 5'd0;
    localparam logic [4:0] KIND_PLUS    = 5'd1;
    localparam logic [4:0] KIND_MINUS   = 5'd2;
    localparam logic [4:0] KIND_STAR    = 5'd3;
    localparam logic [4:0] KIND_SLASH   = 5'd4;
    localparam logic [4:0] KIND_CMP0    = 5'd5;
    localparam logic [4:0] KIND_STRING  = 5'd13;
    localparam logic [4:0] KIND_INT     = 5'd14;
    localparam logic [4:0] KIND_DEC     = 5'd15;
    localparam logic [4:0] KIND_IDENT   = 5'd16;
    localparam logic [4:0] KIND_KEY0    = 5'd17;
    localparam logic [4:0] KIND_END     = 5'd28;
    localparam logic [4:0] KIND_ERROR   = 5'd29;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_INVALID = 3'd1;
    localparam logic [2:0] ERR_POINT2  = 3'd2;
    localparam logic [2:0] ERR_LONE    = 3'd3;
    localparam logic [2:0] ERR_OPEN    = 3'd4;

    localparam logic [1:0] OP_BANG = 2'd0;
    localparam logic [1:0] OP_EQ   = 2'd1;
    localparam logic [1:0] OP_LT   = 2'd2;
    localparam logic [1:0] OP_GT   = 2'd3;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    localparam int KW_COUNT = 11;
    localparam int KW_MAX   = 8;

    // Keyword text right-aligned: the first character sits highest.
    localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
        "IF", "LET", "THEN", "GOTO", "LABEL", "PRINT",
        "INPUT", "ENDIF", "WHILE", "REPEAT", "ENDWHILE"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd2, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd6, 4'd8
    };

    typedef struct packed {
        t_mode      mode;
        logic       set_op;
        logic [1:0] op;
        logic       seen_dec;
        logic       str;
        logic       zero_len;
        logic       emit;
        logic [4:0] kind;
        logic [2:0] err;
        logic       wr0;
    } t_start;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_FF) || (c == CH_CR) ||
               (c == CH_TAB) || (c == CH_VT);
    endfunction

    function automatic t_start start_info(input logic [7:0] c);
        t_start s;
        s = '{mode: MODE_IDLE, set_op: 1'b0, op: OP_BANG, seen_dec: 1'b0, str: 1'b0,
              zero_len: 1'b0, emit: 1'b0, kind: KIND_NEWLINE, err: ERR_NONE, wr0: 1'b0};
        case (c)
            CH_NL: begin
                s.emit = 1'b1;
                s.kind = KIND_NEWLINE;
            end
            CH_PLUS: begin
                s.emit = 1'b1;
                s.kind = KIND_PLUS;
            end
            CH_MINUS: begin
                s.emit = 1'b1;
                s.kind = KIND_MINUS;
            end
            CH_STAR: begin
                s.emit = 1'b1;
                s.kind = KIND_STAR;
            end
            CH_SLASH: begin
                s.emit = 1'b1;
                s.kind = KIND_SLASH;
            end
            CH_BANG: begin
                s.set_op = 1'b1;
                s.op     = OP_BANG;
                s.mode   = MODE_OP;
            end
            CH_EQ: begin
                s.set_op = 1'b1;
                s.op     = OP_EQ;
                s.mode   = MODE_OP;
            end
            CH_LT: begin
                s.set_op = 1'b1;
                s.op     = OP_LT;
                s.mode   = MODE_OP;
            end
            CH_GT: begin
                s.set_op = 1'b1;
                s.op     = OP_GT;
                s.mode   = MODE_OP;
            end
            CH_QUOTE: begin
                s.str  = 1'b1;
                s.mode = MODE_STR;
            end
            CH_POINT: begin
                s.seen_dec = 1'b1;
                s.mode     = MODE_NUM;
            end
            default: begin
                if (is_digit(c)) begin
                    s.mode = MODE_NUM;
                end else if (is_alpha(c) || (c == CH_UNDER)) begin
                    s.wr0  = 1'b1;
                    s.mode = MODE_WORD;
                end else if (is_space(c)) begin
                    s.zero_len = 1'b1;
                end else begin
                    s.emit = 1'b1;
                    s.kind = KIND_ERROR;
                    s.err  = ERR_INVALID;
                    s.mode = MODE_ERR;
                end
            end
        endcase
        return s;
    endfunction

endpackage

// ----- hw/rtl/basic_token_lexer_core.sv -----
// Top level of the BASIC token lexer: stream ports, scan core and result queue.
//
//   channel  dir  payload                                        end flag
//   s_axis   in   tdata: source_byte                             tlast: end_marker
//   m_axis   out  tdata: start_offset, token_length, error_code  tlast: last_of_run
//                 tuser: token_kind
//
// One source byte is taken per cycle; its tokens are ready in the queue the next cycle.
// Bytes that give two tokens drain at one token per cycle through a four-entry queue,
// which sets the rate: ready drops while fewer than two entries are free.
// Synchronous active-low reset returns the scan state to the start of a text and
// empties the queue. A stalled output holds its token; input keeps flowing while two entries are free.
module basic_token_lexer_core #(
    parameter int KEYWORD_CHARS = 8,
    parameter int OFFSET_BITS   = 16,
    parameter int LENGTH_BITS   = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] source_byte
    input  logic                s_axis_tlast,   // end_marker
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // start_offset, token_length, error_code, zero fill
    output logic [((OFFSET_BITS+LENGTH_BITS+3+7)/8)*8-1:0] m_axis_tdata,
    output logic [7:0]          m_axis_tuser,   // [4:0] token_kind, zero fill
    output logic                m_axis_tlast    // last_of_run
);

    localparam int PAY_W   = OFFSET_BITS + LENGTH_BITS + 3;
    localparam int TDATA_W = ((PAY_W + 7) / 8) * 8;
    localparam int ENT_W   = PAY_W + 6;

    logic [1:0]         res_count;
    logic [ENT_W-1:0]   res0, res1;
    logic               accept, pop;
    logic [2:0]         push;
    logic [2:0]         r_cnt;
    logic [1:0]         r_wp, r_rp;
    logic [ENT_W-1:0]   r_queue [4];
    logic [ENT_W-1:0]   head;

    assign s_axis_tready = (r_cnt <= 3'd2);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_cnt != 3'd0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign push          = accept ? {1'b0, res_count} : 3'd0;

    btl_step #(
        .KEYWORD_CHARS(KEYWORD_CHARS),
        .OFFSET_BITS  (OFFSET_BITS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_end    (s_axis_tlast),
        .o_count  (res_count),
        .o_res0   (res0),
        .o_res1   (res1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= '0;
            r_rp  <= '0;
        end else begin
            r_cnt <= r_cnt + push - {2'b00, pop};
            r_wp  <= r_wp + push[1:0];
            if (pop) begin
                r_rp <= r_rp + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push != 3'd0) begin
            r_queue[r_wp] <= res0;
        end
        if (push == 3'd2) begin
            r_queue[r_wp + 2'd1] <= res1;
        end
    end

    assign head         = r_queue[r_rp];
    assign m_axis_tdata = TDATA_W'(head[PAY_W-1:0]);
    assign m_axis_tuser = {3'b000, head[PAY_W+4:PAY_W]};
    assign m_axis_tlast = head[ENT_W-1];

endmodule

// ----- hw/rtl/btl_step.sv -----
// Lexer state and per-byte scan logic: updates state on each request, forms up to two tokens.
module btl_step #(
    parameter int KEYWORD_CHARS = 8,
    parameter int OFFSET_BITS   = 16,
    parameter int LENGTH_BITS   = 8
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_accept,
    input  logic [7:0]                                    i_byte,
    input  logic                                          i_end,
    output logic [1:0]                                    o_count,
    // each result, lowest bit up: start, length, error code, kind, last
    output logic [OFFSET_BITS+LENGTH_BITS+8:0]            o_res0,
    output logic [OFFSET_BITS+LENGTH_BITS+8:0]            o_res1
);

    localparam int KW_IW = $clog2(KEYWORD_CHARS);
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    btl_pkg::t_mode           r_mode, n_mode;
    logic [1:0]               r_op, n_op;
    logic                     r_seen, n_seen;
    logic [LENGTH_BITS-1:0]   r_len, n_len;
    logic [OFFSET_BITS-1:0]   r_start, n_start;
    logic [OFFSET_BITS-1:0]   r_pos, n_pos;
    logic [7:0]               r_word [KEYWORD_CHARS];

    btl_pkg::t_start          si;
    logic                     do_start;
    logic                     wr_en;
    logic [KW_IW-1:0]         wr_idx;
    logic [LENGTH_BITS-1:0]   len_grow;
    logic [OFFSET_BITS-1:0]   pos_inc;
    logic                     num_lone;
    logic [4:0]               num_kind;
    logic [4:0]               kw_kind;
    logic                     kw_hit;
    logic [4:0]               op_kind1;

    logic                     v0, v1;
    logic [4:0]               k0, k1;
    logic [OFFSET_BITS-1:0]   s0, s1;
    logic [LENGTH_BITS-1:0]   l0, l1;
    logic [2:0]               e0, e1;

    always_comb begin
        kw_kind = btl_pkg::KIND_IDENT;
        for (int k = btl_pkg::KW_COUNT - 1; k >= 0; k--) begin
            kw_hit = (32'(r_len) == 32'(btl_pkg::KW_LEN[k]));
            for (int j = 0; j < btl_pkg::KW_MAX; j++) begin
                if (j < int'(btl_pkg::KW_LEN[k])) begin
                    kw_hit = kw_hit && (r_word[j] ==
                        btl_pkg::KW_TEXT[k][(int'(btl_pkg::KW_LEN[k]) - 1 - j) * 8 +: 8]);
                end
            end
            if (kw_hit) begin
                kw_kind = 5'(32'(btl_pkg::KIND_KEY0) + k);
            end
        end
    end

    always_comb begin
        si       = btl_pkg::start_info(i_byte);
        len_grow = (r_len < LEN_MAX) ? r_len + 1'b1 : r_len;
        pos_inc  = (r_pos < OFF_MAX) ? r_pos + 1'b1 : r_pos;
        num_lone = (r_len == LENGTH_BITS'(1)) && r_seen;
        num_kind = r_seen ? btl_pkg::KIND_DEC : btl_pkg::KIND_INT;
        op_kind1 = btl_pkg::KIND_CMP0 + {2'b00, r_op, 1'b0};

        n_mode   = r_mode;
        n_op     = r_op;
        n_seen   = r_seen;
        n_len    = r_len;
        n_start  = r_start;
        n_pos    = r_pos;
        do_start = 1'b0;
        wr_en    = 1'b0;
        wr_idx   = r_len[KW_IW-1:0];

        v0 = 1'b0;
        k0 = btl_pkg::KIND_NEWLINE;
        s0 = r_start;
        l0 = '0;
        e0 = btl_pkg::ERR_NONE;
        v1 = 1'b0;
        k1 = btl_pkg::KIND_NEWLINE;
        s1 = r_start;
        l1 = '0;
        e1 = btl_pkg::ERR_NONE;

        if (i_end) begin
            case (r_mode)
                btl_pkg::MODE_OP: begin
                    v0 = 1'b1;
                    k0 = op_kind1;
                    l0 = LENGTH_BITS'(1);
                end
                btl_pkg::MODE_STR: begin
                    v0 = 1'b1;
                    k0 = btl_pkg::KIND_ERROR;
                    e0 = btl_pkg::ERR_OPEN;
                end
                btl_pkg::MODE_NUM: begin
                    v0 = 1'b1;
                    if (num_lone) begin
                        k0 = btl_pkg::KIND_ERROR;
                        e0 = btl_pkg::ERR_LONE;
                    end else begin
                        k0 = num_kind;
                        l0 = r_len;
                    end
                end
                btl_pkg::MODE_WORD: begin
                    v0 = 1'b1;
                    k0 = kw_kind;
                    l0 = r_len;
                end
                default: begin
                end
            endcase
            if (v0) begin
                v1 = 1'b1;
                k1 = btl_pkg::KIND_END;
                s1 = r_pos;
            end else begin
                v0 = 1'b1;
                k0 = btl_pkg::KIND_END;
                s0 = r_pos;
            end
            n_mode  = btl_pkg::MODE_IDLE;
            n_op    = btl_pkg::OP_BANG;
            n_seen  = 1'b0;
            n_len   = '0;
            n_start = '0;
            n_pos   = '0;
        end else begin
            n_pos = pos_inc;
            case (r_mode)
                btl_pkg::MODE_OP: begin
                    v0 = 1'b1;
                    if (i_byte == btl_pkg::CH_EQ) begin
                        k0     = op_kind1 + 5'd1;
                        l0     = LENGTH_BITS'(2);
                        n_mode = btl_pkg::MODE_IDLE;
                    end else begin
                        k0       = op_kind1;
                        l0       = LENGTH_BITS'(1);
                        do_start = 1'b1;
                    end
                end
                btl_pkg::MODE_STR: begin
                    if (i_byte == btl_pkg::CH_QUOTE) begin
                        v0     = 1'b1;
                        k0     = btl_pkg::KIND_STRING;
                        l0     = r_len;
                        n_mode = btl_pkg::MODE_IDLE;
                    end else begin
                        n_len = len_grow;
                    end
                end
                btl_pkg::MODE_NUM: begin
                    if (btl_pkg::is_digit(i_byte)) begin
                        n_len = len_grow;
                    end else if (i_byte == btl_pkg::CH_POINT) begin
                        if (r_seen) begin
                            v0     = 1'b1;
                            k0     = btl_pkg::KIND_ERROR;
                            s0     = r_pos;
                            e0     = btl_pkg::ERR_POINT2;
                            n_mode = btl_pkg::MODE_ERR;
                        end else begin
                            n_seen = 1'b1;
                            n_len  = len_grow;
                        end
                    end else if (num_lone) begin
                        v0     = 1'b1;
                        k0     = btl_pkg::KIND_ERROR;
                        e0     = btl_pkg::ERR_LONE;
                        n_mode = btl_pkg::MODE_ERR;
                    end else begin
                        v0       = 1'b1;
                        k0       = num_kind;
                        l0       = r_len;
                        do_start = 1'b1;
                    end
                end
                btl_pkg::MODE_WORD: begin
                    if (btl_pkg::is_alpha(i_byte) || btl_pkg::is_digit(i_byte) ||
                        (i_byte == btl_pkg::CH_UNDER)) begin
                        wr_en = (32'(r_len) < KEYWORD_CHARS);
                        n_len = len_grow;
                    end else begin
                        v0       = 1'b1;
                        k0       = kw_kind;
                        l0       = r_len;
                        do_start = 1'b1;
                    end
                end
                btl_pkg::MODE_ERR: begin
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase

            if (do_start) begin
                n_mode  = si.mode;
                n_start = si.str ? pos_inc : r_pos;
                n_len   = (si.str || si.zero_len) ? '0 : LENGTH_BITS'(1);
                n_seen  = si.seen_dec;
                if (si.set_op) begin
                    n_op = si.op;
                end
                if (si.wr0) begin
                    wr_en  = 1'b1;
                    wr_idx = '0;
                end
                if (si.emit) begin
                    if (v0) begin
                        v1 = 1'b1;
                        k1 = si.kind;
                        s1 = r_pos;
                        l1 = (si.kind == btl_pkg::KIND_ERROR) ? '0 : LENGTH_BITS'(1);
                        e1 = si.err;
                    end else begin
                        v0 = 1'b1;
                        k0 = si.kind;
                        s0 = r_pos;
                        l0 = (si.kind == btl_pkg::KIND_ERROR) ? '0 : LENGTH_BITS'(1);
                        e0 = si.err;
                    end
                end
            end
        end
    end

    assign o_count = v1 ? 2'd2 : (v0 ? 2'd1 : 2'd0);
    assign o_res0  = {~v1, k0, e0, l0, s0};
    assign o_res1  = {1'b1, k1, e1, l1, s1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= btl_pkg::MODE_IDLE;
            r_op    <= btl_pkg::OP_BANG;
            r_seen  <= 1'b0;
            r_len   <= '0;
            r_start <= '0;
            r_pos   <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_op    <= n_op;
            r_seen  <= n_seen;
            r_len   <= n_len;
            r_start <= n_start;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && wr_en) begin
            r_word[wr_idx] <= i_byte;
        end
    end

endmodule

// ----- tb/sv/tb_basic_token_lexer_core.sv -----
// Self-checking testbench for the BASIC token lexer core: directed and random text streams checked per token.
module tb_basic_token_lexer_core;

    localparam int TDATA_W     = ((16 + 8 + 3 + 7) / 8) * 8;
    localparam int STALL_LIMIT = 4000;
    localparam int ITEM_TARGET = 1900;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [7:0]  len;
        logic [2:0]  err;
        logic        last;
    } t_lex_token;

    class t_token_scoreboard;
        localparam int          WORD_CHARS = 8;
        localparam logic [15:0] POS_MAX    = 16'hFFFF;
        localparam logic [7:0]  LEN_MAX    = 8'hFF;

        t_lex_token     expected_tokens [$];
        string          kw_names [11];
        btl_pkg::t_mode mode;
        logic [1:0]     pend_op;
        logic           point_seen;
        logic [7:0]     word [WORD_CHARS];
        logic [7:0]     run_len;
        logic [15:0]    run_at;
        logic [15:0]    pos_ctr;
        int             failures;
        int             tokens_seen;

        function new();
            kw_names = '{"IF", "LET", "THEN", "GOTO", "LABEL", "PRINT",
                         "INPUT", "ENDIF", "WHILE", "REPEAT", "ENDWHILE"};
            mode        = btl_pkg::MODE_IDLE;
            pend_op     = btl_pkg::OP_BANG;
            point_seen  = 1'b0;
            run_len     = 8'd0;
            run_at      = 16'd0;
            pos_ctr     = 16'd0;
            failures    = 0;
            tokens_seen = 0;
            foreach (word[i]) word[i] = 8'd0;
        endfunction

        function bit digit_char(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit word_char(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
                   c == btl_pkg::CH_UNDER || digit_char(c);
        endfunction

        function bit blank_char(logic [7:0] c);
            return c == btl_pkg::CH_SPACE || c == btl_pkg::CH_TAB || c == btl_pkg::CH_VT ||
                   c == btl_pkg::CH_FF || c == btl_pkg::CH_CR;
        endfunction

        function void add_token(logic [4:0] kind, logic [15:0] start, logic [7:0] len,
                                logic [2:0] err);
            t_lex_token tok;
            tok = '{kind, start, len, err, 1'b0};
            expected_tokens = {expected_tokens, tok};
        endfunction

        function void grow_run();
            if (run_len != LEN_MAX) run_len++;
        endfunction

        function void begin_token(logic [7:0] c, logic [15:0] p);
            mode       = btl_pkg::MODE_IDLE;
            run_at     = p;
            run_len    = 8'd1;
            point_seen = 1'b0;
            case (c)
                btl_pkg::CH_NL:    add_token(btl_pkg::KIND_NEWLINE, p, 8'd1, btl_pkg::ERR_NONE);
                btl_pkg::CH_PLUS:  add_token(btl_pkg::KIND_PLUS, p, 8'd1, btl_pkg::ERR_NONE);
                btl_pkg::CH_MINUS: add_token(btl_pkg::KIND_MINUS, p, 8'd1, btl_pkg::ERR_NONE);
                btl_pkg::CH_STAR:  add_token(btl_pkg::KIND_STAR, p, 8'd1, btl_pkg::ERR_NONE);
                btl_pkg::CH_SLASH: add_token(btl_pkg::KIND_SLASH, p, 8'd1, btl_pkg::ERR_NONE);
                btl_pkg::CH_BANG: begin
                    pend_op = btl_pkg::OP_BANG;
                    mode    = btl_pkg::MODE_OP;
                end
                btl_pkg::CH_EQ: begin
                    pend_op = btl_pkg::OP_EQ;
                    mode    = btl_pkg::MODE_OP;
                end
                btl_pkg::CH_LT: begin
                    pend_op = btl_pkg::OP_LT;
                    mode    = btl_pkg::MODE_OP;
                end
                btl_pkg::CH_GT: begin
                    pend_op = btl_pkg::OP_GT;
                    mode    = btl_pkg::MODE_OP;
                end
                btl_pkg::CH_QUOTE: begin
                    run_at  = (p != POS_MAX) ? p + 16'd1 : p;
                    run_len = 8'd0;
                    mode    = btl_pkg::MODE_STR;
                end
                btl_pkg::CH_POINT: begin
                    point_seen = 1'b1;
                    mode       = btl_pkg::MODE_NUM;
                end
                default: begin
                    if (digit_char(c)) begin
                        mode = btl_pkg::MODE_NUM;
                    end else if (word_char(c)) begin
                        word[0] = c;
                        mode    = btl_pkg::MODE_WORD;
                    end else if (blank_char(c)) begin
                        run_len = 8'd0;
                    end else begin
                        add_token(btl_pkg::KIND_ERROR, p, 8'd0, btl_pkg::ERR_INVALID);
                        mode = btl_pkg::MODE_ERR;
                    end
                end
            endcase
        endfunction

        function bit close_number();
            if (run_len == 8'd1 && point_seen) begin
                add_token(btl_pkg::KIND_ERROR, run_at, 8'd0, btl_pkg::ERR_LONE);
                mode = btl_pkg::MODE_ERR;
                return 1'b0;
            end
            add_token(point_seen ? btl_pkg::KIND_DEC : btl_pkg::KIND_INT, run_at, run_len,
                      btl_pkg::ERR_NONE);
            mode = btl_pkg::MODE_IDLE;
            return 1'b1;
        endfunction

        function void close_word();
            logic [4:0] kind;
            string      kw;
            bit         hit;
            kind = btl_pkg::KIND_IDENT;
            for (int k = 0; k < 11; k++) begin
                kw = kw_names[k];
                if (kw.len() == int'(run_len)) begin
                    hit = 1'b1;
                    for (int i = 0; i < kw.len(); i++) begin
                        if (word[i] != kw[i]) hit = 1'b0;
                    end
                    if (hit) begin
                        kind = 5'(btl_pkg::KIND_KEY0 + k);
                        break;
                    end
                end
            end
            add_token(kind, run_at, run_len, btl_pkg::ERR_NONE);
            mode = btl_pkg::MODE_IDLE;
        endfunction

        function void note_request(logic [7:0] c, logic endm);
            int          n0;
            logic [15:0] p;
            n0 = expected_tokens.size();
            p  = pos_ctr;
            if (endm) begin
                case (mode)
                    btl_pkg::MODE_OP:   add_token(btl_pkg::KIND_CMP0 + {pend_op, 1'b0}, run_at,
                                                  8'd1, btl_pkg::ERR_NONE);
                    btl_pkg::MODE_STR:  add_token(btl_pkg::KIND_ERROR, run_at, 8'd0,
                                                  btl_pkg::ERR_OPEN);
                    btl_pkg::MODE_NUM:  void'(close_number());
                    btl_pkg::MODE_WORD: close_word();
                    default: ;
                endcase
                add_token(btl_pkg::KIND_END, pos_ctr, 8'd0, btl_pkg::ERR_NONE);
                mode       = btl_pkg::MODE_IDLE;
                pend_op    = btl_pkg::OP_BANG;
                point_seen = 1'b0;
                run_len    = 8'd0;
                run_at     = 16'd0;
                pos_ctr    = 16'd0;
            end else begin
                if (pos_ctr != POS_MAX) pos_ctr++;
                case (mode)
                    btl_pkg::MODE_OP: begin
                        if (c == btl_pkg::CH_EQ) begin
                            add_token(btl_pkg::KIND_CMP0 + {pend_op, 1'b1}, run_at, 8'd2,
                                      btl_pkg::ERR_NONE);
                            mode = btl_pkg::MODE_IDLE;
                        end else begin
                            add_token(btl_pkg::KIND_CMP0 + {pend_op, 1'b0}, run_at, 8'd1,
                                      btl_pkg::ERR_NONE);
                            begin_token(c, p);
                        end
                    end
                    btl_pkg::MODE_STR: begin
                        if (c == btl_pkg::CH_QUOTE) begin
                            add_token(btl_pkg::KIND_STRING, run_at, run_len, btl_pkg::ERR_NONE);
                            mode = btl_pkg::MODE_IDLE;
                        end else begin
                            grow_run();
                        end
                    end
                    btl_pkg::MODE_NUM: begin
                        if (digit_char(c)) begin
                            grow_run();
                        end else if (c == btl_pkg::CH_POINT) begin
                            if (point_seen) begin
                                add_token(btl_pkg::KIND_ERROR, p, 8'd0, btl_pkg::ERR_POINT2);
                                mode = btl_pkg::MODE_ERR;
                            end else begin
                                point_seen = 1'b1;
                                grow_run();
                            end
                        end else if (close_number()) begin
                            begin_token(c, p);
                        end
                    end
                    btl_pkg::MODE_WORD: begin
                        if (word_char(c)) begin
                            if (run_len < WORD_CHARS) word[run_len[2:0]] = c;
                            grow_run();
                        end else begin
                            close_word();
                            begin_token(c, p);
                        end
                    end
                    btl_pkg::MODE_ERR: ;
                    default: begin_token(c, p);
                endcase
            end
            if (expected_tokens.size() > n0) begin
                expected_tokens[expected_tokens.size() - 1].last = 1'b1;
            end
        endfunction

        function void check_token(logic [7:0] user, logic [31:0] data, logic last);
            t_lex_token e;
            tokens_seen++;
            if (expected_tokens.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected token: kind %0d start %0d len %0d err %0d last %0b",
                             user[4:0], data[15:0], data[23:16], data[26:24], last);
                end
                return;
            end
            e = expected_tokens.pop_front();
            if (user !== {3'd0, e.kind} || data !== {5'd0, e.err, e.len, e.start} ||
                last !== e.last) begin
                failures++;
                if (failures <= 10) begin
                    $display("token mismatch: expected kind %0d start %0d len %0d err %0d last %0b",
                             e.kind, e.start, e.len, e.err, e.last);
                    $display("                got      kind %0d start %0d len %0d err %0d last %0b",
                             user, data[15:0], data[23:16], data[31:24], last);
                end
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;   // [7:0] source_byte
    logic               s_axis_tlast;   // end_marker
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;   // [15:0] start_offset, [23:16] token_length,
                                        // [26:24] error_code, zero fill
    logic [7:0]         m_axis_tuser;   // [4:0] token_kind, zero fill
    logic               m_axis_tlast;   // last_of_run

    t_token_scoreboard sb;
    bit                quiet;
    int                items_sent;
    int                stall_cycles;

    localparam logic [7:0] OP_CHARS [9] = '{btl_pkg::CH_PLUS, btl_pkg::CH_MINUS,
                                            btl_pkg::CH_STAR, btl_pkg::CH_SLASH,
                                            btl_pkg::CH_NL, btl_pkg::CH_BANG,
                                            btl_pkg::CH_EQ, btl_pkg::CH_LT, btl_pkg::CH_GT};
    localparam logic [7:0] BLANKS [5] = '{btl_pkg::CH_SPACE, btl_pkg::CH_TAB, btl_pkg::CH_VT,
                                          btl_pkg::CH_FF, btl_pkg::CH_CR};

    basic_token_lexer_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_word_char(input bit first);
        int r;
        r = $urandom_range(0, first ? 52 : 62);
        if (r < 26) return 8'(8'h41 + r);
        if (r < 52) return 8'(8'h61 + r - 26);
        if (r == 52) return btl_pkg::CH_UNDER;
        return 8'(8'h30 + r - 53);
    endfunction

    function automatic logic [7:0] pick_string_char();
        logic [7:0] c;
        do begin
            if ($urandom_range(0, 99) < 85) c = 8'($urandom_range(32, 126));
            else c = 8'($urandom_range(0, 255));
        end while (c == btl_pkg::CH_QUOTE);
        return c;
    endfunction

    task automatic put_request(input logic [7:0] c, input logic endm);
        int gap;
        items_sent++;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= endm ? 8'($urandom) : c;
        s_axis_tlast  <= endm;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic put_byte(input logic [7:0] c);
        put_request(c, 1'b0);
    endtask

    task automatic put_end();
        put_request(8'd0, 1'b1);
    endtask

    task automatic send_chars(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic send_blanks(input int n);
        repeat (n) put_byte(BLANKS[$urandom_range(0, 4)]);
    endtask

    task automatic send_digits(input int n);
        repeat (n) put_byte(8'(8'h30 + $urandom_range(0, 9)));
    endtask

    task automatic send_word(input int n);
        for (int i = 0; i < n; i++) put_byte(pick_word_char(i == 0));
    endtask

    task automatic send_keyword();
        string      kw;
        logic [7:0] c;
        kw = sb.kw_names[$urandom_range(0, 10)];
        for (int i = 0; i < kw.len(); i++) begin
            c = kw[i];
            if ($urandom_range(0, 9) == 0) c = c ^ 8'h20;
            put_byte(c);
        end
        if ($urandom_range(0, 9) == 0) put_byte(pick_word_char(1'b0));
    endtask

    task automatic send_number(input int ndig);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            put_byte(btl_pkg::CH_POINT);
        end else begin
            if (r != 1) send_digits(ndig);
            if (r < 8) begin
                put_byte(btl_pkg::CH_POINT);
                send_digits($urandom_range(0, 3));
                if (r == 2) put_byte(btl_pkg::CH_POINT);
            end
        end
    endtask

    task automatic send_string(input int n, input bit closed);
        put_byte(btl_pkg::CH_QUOTE);
        repeat (n) put_byte(pick_string_char());
        if (closed) put_byte(btl_pkg::CH_QUOTE);
    endtask

    task automatic send_op();
        int idx;
        idx = $urandom_range(0, 8);
        put_byte(OP_CHARS[idx]);
        if (idx >= 5 && $urandom_range(0, 1) == 0) put_byte(btl_pkg::CH_EQ);
    endtask

    task automatic send_text(input int ntok);
        int r;
        for (int t = 0; t < ntok; t++) begin
            r = $urandom_range(0, 99);
            if (r < 18) send_keyword();
            else if (r < 36) send_word($urandom_range(1, 12));
            else if (r < 54) send_number($urandom_range(1, 6));
            else if (r < 64) send_string($urandom_range(0, 10),
                                         t != ntok - 1 || $urandom_range(0, 3) != 0);
            else if (r < 97) send_op();
            else put_byte(8'($urandom_range(0, 255)));
            r = $urandom_range(0, 9);
            if (r >= 3) send_blanks(r < 8 ? 1 : 2);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_token(m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        int  stall_left;
        bit  held;
        stall_left    = 0;
        held          = 1'b0;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!held && sb.tokens_seen >= 250) begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int text_no;
        sb            = new();
        quiet         = 1'b0;
        items_sent    = 0;
        stall_cycles  = 0;
        text_no       = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_chars("IF x>=1.5\"a b\"");
        put_end();
        send_chars("1..");
        put_end();
        send_chars(". ");
        put_end();
        send_chars("\"ab");
        put_end();
        put_byte(8'h00);
        put_byte(8'hFF);
        put_end();

        while (items_sent < ITEM_TARGET) begin
            quiet = ($urandom_range(0, 7) == 0);
            case (text_no)
                3:       send_string(300, 1'b1);
                6:       send_word(270);
                9:       send_digits(260);
                default: send_text($urandom_range(0, 12));
            endcase
            put_end();
            text_no++;
        end

        quiet = 1'b1;
        send_chars("7<\"zz\"1\"k");
        put_end();

        s_axis_tvalid <= 1'b0;
        while (sb.expected_tokens.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.failures == 0 && sb.expected_tokens.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
